// ===== design/stable_sorted_priority_queue_top_defines.svh =====
// Assertion macros for the stable sorted priority queue.
// Both sample on aclk and are switched off while aresetn is low.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSPQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sspq_pkg.sv =====
`default_nettype none

package sspq_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_SERVED   = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    // Request kinds.
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_SERVE  = 1'b1
    } command_t;

    localparam int PRIO_W = 8;
    localparam int NAME_LOW_W = 64;
    localparam int NAME_HIGH_W = 8;
    localparam int OCC_W = 8;

    // One stored entry: priority and opaque payload.
    typedef struct packed {
        logic [NAME_HIGH_W-1:0] name_high;
        logic [NAME_LOW_W-1:0]  name_low;
        logic [PRIO_W-1:0]      prio;
    } entry_t;

    // Moves broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic serve;
    } chain_ctrl_t;

endpackage

`default_nettype wire

// ===== design/sspq_cell.sv =====
`default_nettype none

module sspq_cell (
    input  wire logic                  aclk,
    input  wire sspq_pkg::chain_ctrl_t ctrl,
    input  wire logic                  occupied,
    input  wire sspq_pkg::entry_t      new_entry,
    input  wire sspq_pkg::entry_t      left_entry,
    input  wire sspq_pkg::entry_t      right_entry,
    input  wire logic                  left_gt,
    output sspq_pkg::entry_t           entry,
    output logic                       gt
);

    sspq_pkg::entry_t entry_reg;
    sspq_pkg::entry_t entry_next;

    // This cell holds an entry that must move behind the new one.
    assign gt    = occupied && (entry_reg.prio > new_entry.prio);
    assign entry = entry_reg;

    // On insert, cells past the slot take their left neighbor and the first
    // cell that is greater or free takes the new entry. On serve, all shift left.
    always_comb begin
        entry_next = entry_reg;
        priority if (ctrl.insert) begin
            if (left_gt) begin
                entry_next = left_entry;
            end else if (gt || !occupied) begin
                entry_next = new_entry;
            end
        end else if (ctrl.serve) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// ===== design/stable_sorted_priority_queue_top.sv =====
`default_nettype none
`include "stable_sorted_priority_queue_top_defines.svh"

// Stable sorted priority queue built as a chain of DEPTH cells, each holding
// one entry in ascending priority order, equal priorities in arrival order.
// One request is taken every cycle unless the output stalls; its result is
// registered in the next cycle; the rate rests on the compare every cell
// makes against the broadcast priority, followed by its shift to a neighbor.
// An insert into a full queue returns status full, a serve on an empty queue
// returns status empty; every result carries the occupancy (low 8 bits).
// A request is accepted while the result register is empty or being taken.
module stable_sorted_priority_queue_top #(
    parameter int DEPTH = 128
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // priority_req[7:0], name_low[71:8], name_high[79:72]
    input  wire logic [0:0]  s_tuser,   // command[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // served_priority[7:0], served_name_low[71:8],
                                        // served_name_high[79:72], occupancy[87:80]
    output logic [1:0]       m_tuser    // status[1:0]
);

    localparam int CW = $clog2(DEPTH + 1);

    logic                  accept;
    sspq_pkg::entry_t      new_entry;
    sspq_pkg::chain_ctrl_t ctrl;
    logic                  is_full;
    logic                  is_empty;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    sspq_pkg::entry_t cell_entry [DEPTH];
    logic [DEPTH-1:0] cell_gt;

    logic                        m_valid_reg;
    logic                        m_valid_next;
    sspq_pkg::status_t           status_reg;
    sspq_pkg::status_t           status_next;
    sspq_pkg::entry_t            served_reg;
    sspq_pkg::entry_t            served_next;
    logic [sspq_pkg::OCC_W-1:0]  occ_reg;
    logic [sspq_pkg::OCC_W-1:0]  occ_next;

    // Request decode.
    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign new_entry = s_tdata;
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign ctrl.insert = accept && (s_tuser[0] == sspq_pkg::CMD_INSERT) && !is_full;
    assign ctrl.serve  = accept && (s_tuser[0] == sspq_pkg::CMD_SERVE) && !is_empty;

    // Chain of cells; cell 0 is the front of the queue.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(i);
        sspq_pkg::entry_t left_e;
        sspq_pkg::entry_t right_e;
        logic             left_g;

        if (i == 0) begin : g_head
            assign left_e = new_entry;
            assign left_g = 1'b0;
        end else begin : g_body
            assign left_e = cell_entry[i-1];
            assign left_g = cell_gt[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_e = cell_entry[i];
        end else begin : g_inner
            assign right_e = cell_entry[i+1];
        end

        sspq_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .occupied    (IDX < count_reg),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .right_entry (right_e),
            .left_gt     (left_g),
            .entry       (cell_entry[i]),
            .gt          (cell_gt[i])
        );
    end

    // Occupancy count and result register contents.
    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        served_next  = served_reg;
        occ_next     = occ_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next = 1'b1;
            served_next  = '0;
            if (ctrl.insert) begin
                count_next  = count_reg + CW'(1);
                status_next = sspq_pkg::ST_INSERTED;
            end else if (ctrl.serve) begin
                count_next  = count_reg - CW'(1);
                status_next = sspq_pkg::ST_SERVED;
                served_next = cell_entry[0];
            end else if (s_tuser[0] == sspq_pkg::CMD_INSERT) begin
                status_next = sspq_pkg::ST_FULL;
            end else begin
                status_next = sspq_pkg::ST_EMPTY;
            end
            occ_next = sspq_pkg::OCC_W'(count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        status_reg <= status_next;
        served_reg <= served_next;
        occ_reg    <= occ_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {occ_reg, served_reg};

    // Checks on the count, on the output stall and on the queue order.
    `SSPQ_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CW'(DEPTH), "count beyond depth")
    `SSPQ_ASSERT_NEXT(a_insert_count, ctrl.insert, count_reg == $past(count_reg) + CW'(1), "insert did not grow count")
    `SSPQ_ASSERT_SAME(a_no_drop, !s_tready, m_tvalid, "stall without pending result")
    `SSPQ_ASSERT_SAME(a_front_order, m_valid_reg && status_reg == sspq_pkg::ST_SERVED && !is_empty, served_reg.prio <= cell_entry[0].prio, "front below served priority")

endmodule

`default_nettype wire
